@@ rtl/core/lldq_pkg.sv @@
// Shared types and codes for the linked list deque with cursor.
package lldq_pkg;

	// Operation codes carried on the command channel
	typedef enum logic [3:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_APPEND     = 4'd1,
		OP_POP_FRONT  = 4'd2,
		OP_POP_BACK   = 4'd3,
		OP_REWIND     = 4'd4,
		OP_NEXT       = 4'd5,
		OP_GET        = 4'd6,
		OP_REMOVE     = 4'd7,
		OP_CLEAR      = 4'd8
	} op_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_FULL      = 3'd2,
		ST_NO_CURSOR = 3'd3,
		ST_ENDED     = 3'd4
	} status_t;

	// Sequencer states: wait for a command, then execute on the read data
	typedef enum logic {
		SEQ_IDLE = 1'b0,
		SEQ_EXEC = 1'b1
	} seq_t;

endpackage

@@ rtl/core/lldq_if.sv @@
// Command and response channel interfaces of the deque.
interface lldq_cmd_if #(
	parameter int DATA_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [3:0]            opcode;
	logic [DATA_WIDTH-1:0] payload_in;

	modport source (output valid, output opcode, output payload_in, input ready);
	modport sink   (input valid, input opcode, input payload_in, output ready);
endinterface

interface lldq_rsp_if #(
	parameter int DATA_WIDTH = 32,
	parameter int COUNT_WIDTH = 5
);
	logic                   valid;
	logic                   ready;
	logic [2:0]             status;
	logic [DATA_WIDTH-1:0]  payload_out;
	logic [COUNT_WIDTH-1:0] element_count;
	logic                   cursor_valid;

	modport source (output valid, output status, output payload_out,
		output element_count, output cursor_valid, input ready);
	modport sink   (input valid, input status, input payload_out,
		input element_count, input cursor_valid, output ready);
endinterface

@@ rtl/core/lldq_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
module lldq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/linked_list_deque_with_cursor_unit.sv @@
// Bounded doubly linked deque with one cursor, held in node memories.
//
// Usage: one command per transfer on cmd (opcode, payload_in); each command
// gives exactly one response transfer on rsp (status, payload_out,
// element_count, cursor_valid), in command order.
// Timing: at the transfer the command is captured and the node payload,
// next link, prev link and free stack memories are read (registered read
// data); the execute step then updates the links and registers and loads
// the response register once it is free. A new command is taken only after
// the execute step of the previous one, as cmd.ready is low until then.
// cmd.ready is high whenever the sequencer is idle, so a command is taken
// while the previous response still waits in the output register.
// Stall: if rsp is stalled, the execute step holds until the output
// register is free; nothing is dropped and state does not change.
// Reset: arst_n empties the list and invalidates the cursor at once. Free
// nodes are tracked by a fill mark plus a stack of returned nodes, so no
// clearing pass is needed and the block accepts a command right after reset.
// Clear works the same way in a single command.
module linked_list_deque_with_cursor_unit #(
	parameter int NODE_COUNT = 16,
	parameter int DATA_WIDTH = 32,
	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1,
	localparam int CW = $clog2(NODE_COUNT + 1)
) (
	input  logic       clk,
	input  logic       arst_n,
	lldq_cmd_if.sink   cmd,
	lldq_rsp_if.source rsp
);

	localparam logic [CW-1:0] FULL_CNT = CW'(NODE_COUNT);

	// Sequencer and list registers
	lldq_pkg::seq_t        state_q, state_d;
	logic [3:0]            op_s1;
	logic [DATA_WIDTH-1:0] word_s1;
	logic [AW-1:0]         head_q, head_d;
	logic [AW-1:0]         tail_q, tail_d;
	logic [AW-1:0]         cur_q, cur_d;
	logic                  cv_q, cv_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic [CW-1:0]         sc_q, sc_d;
	logic [CW-1:0]         fresh_q, fresh_d;

	// Response register
	logic                  out_v_q;
	logic [2:0]            out_st_q;
	logic [DATA_WIDTH-1:0] out_pay_q;
	logic [CW-1:0]         out_cnt_q;
	logic                  out_cv_q;

	// Memory ports
	logic                  cmd_xfer, exec_go;
	logic [AW-1:0]         node_ra, free_ra;
	logic [CW-1:0]         sc_m1;
	logic [DATA_WIDTH-1:0] rd_pay;
	logic [AW-1:0]         rd_next, rd_prev, rd_free;
	logic                  pay_we, nxt_we, prv_we, fs_we;
	logic [AW-1:0]         pay_wa, nxt_wa, prv_wa;
	logic [DATA_WIDTH-1:0] pay_wd;
	logic [AW-1:0]         nxt_wd, prv_wd;

	// Execute results
	lldq_pkg::status_t     st_d;
	logic [DATA_WIDTH-1:0] pay_d;
	logic [AW-1:0]         n_alloc, n_end;

	assign cmd.ready = (state_q == lldq_pkg::SEQ_IDLE);
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign exec_go   = (state_q == lldq_pkg::SEQ_EXEC) && (!out_v_q || rsp.ready);

	// Read addresses chosen from the incoming opcode
	always_comb begin
		case (cmd.opcode)
			lldq_pkg::OP_POP_FRONT: node_ra = head_q;
			lldq_pkg::OP_POP_BACK:  node_ra = tail_q;
			default:                node_ra = cur_q;
		endcase
	end

	assign sc_m1   = sc_q - CW'(1);
	assign free_ra = sc_m1[AW-1:0];

	lldq_ram #(.DEPTH(NODE_COUNT), .WIDTH(DATA_WIDTH)) u_pay_ram (
		.clk(clk), .we(pay_we), .waddr(pay_wa), .wdata(pay_wd),
		.re(cmd_xfer), .raddr(node_ra), .rdata(rd_pay)
	);

	lldq_ram #(.DEPTH(NODE_COUNT), .WIDTH(AW)) u_next_ram (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.re(cmd_xfer), .raddr(node_ra), .rdata(rd_next)
	);

	lldq_ram #(.DEPTH(NODE_COUNT), .WIDTH(AW)) u_prev_ram (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
		.re(cmd_xfer), .raddr(node_ra), .rdata(rd_prev)
	);

	lldq_ram #(.DEPTH(NODE_COUNT), .WIDTH(AW)) u_free_ram (
		.clk(clk), .we(fs_we), .waddr(sc_q[AW-1:0]), .wdata(n_end),
		.re(cmd_xfer), .raddr(free_ra), .rdata(rd_free)
	);

	// Node taken from the free pool: returned stack first, then fresh slots
	assign n_alloc = (sc_q != '0) ? rd_free : fresh_q[AW-1:0];

	// Execute step: next state, link updates and response
	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		tail_d  = tail_q;
		cur_d   = cur_q;
		cv_d    = cv_q;
		cnt_d   = cnt_q;
		sc_d    = sc_q;
		fresh_d = fresh_q;
		st_d    = lldq_pkg::ST_OK;
		pay_d   = '0;
		pay_we  = 1'b0;
		pay_wa  = n_alloc;
		pay_wd  = word_s1;
		nxt_we  = 1'b0;
		nxt_wa  = n_alloc;
		nxt_wd  = head_q;
		prv_we  = 1'b0;
		prv_wa  = head_q;
		prv_wd  = n_alloc;
		fs_we   = 1'b0;
		n_end   = (op_s1 == lldq_pkg::OP_POP_BACK) ? tail_q : head_q;

		if (cmd_xfer) begin
			state_d = lldq_pkg::SEQ_EXEC;
		end

		if (exec_go) begin
			state_d = lldq_pkg::SEQ_IDLE;
			case (op_s1)
				lldq_pkg::OP_PUSH_FRONT, lldq_pkg::OP_APPEND: begin
					if (cnt_q == FULL_CNT) begin
						st_d = lldq_pkg::ST_FULL;
					end else begin
						pay_we = 1'b1;
						if (cnt_q == '0) begin
							head_d = n_alloc;
							tail_d = n_alloc;
						end else if (op_s1 == lldq_pkg::OP_PUSH_FRONT) begin
							// new node points forward at the old head
							nxt_we = 1'b1;
							nxt_wa = n_alloc;
							nxt_wd = head_q;
							prv_we = 1'b1;
							prv_wa = head_q;
							prv_wd = n_alloc;
							head_d = n_alloc;
						end else begin
							// new node points back at the old tail
							prv_we = 1'b1;
							prv_wa = n_alloc;
							prv_wd = tail_q;
							nxt_we = 1'b1;
							nxt_wa = tail_q;
							nxt_wd = n_alloc;
							tail_d = n_alloc;
						end
						if (sc_q != '0) begin
							sc_d = sc_q - CW'(1);
						end else begin
							fresh_d = fresh_q + CW'(1);
						end
						cnt_d = cnt_q + CW'(1);
					end
				end
				lldq_pkg::OP_POP_FRONT, lldq_pkg::OP_POP_BACK: begin
					if (cnt_q == '0) begin
						st_d = lldq_pkg::ST_EMPTY;
					end else begin
						pay_d = rd_pay;
						if (cnt_q != CW'(1)) begin
							if (op_s1 == lldq_pkg::OP_POP_FRONT) begin
								head_d = rd_next;
							end else begin
								tail_d = rd_prev;
							end
						end
						if (cv_q && (cur_q == n_end)) begin
							cv_d = 1'b0;
						end
						fs_we = 1'b1;
						sc_d  = sc_q + CW'(1);
						cnt_d = cnt_q - CW'(1);
					end
				end
				lldq_pkg::OP_REWIND: begin
					cur_d = head_q;
					cv_d  = (cnt_q != '0);
				end
				lldq_pkg::OP_NEXT: begin
					if (!cv_q) begin
						st_d = lldq_pkg::ST_NO_CURSOR;
					end else if (cur_q == tail_q) begin
						cv_d = 1'b0;
						st_d = lldq_pkg::ST_ENDED;
					end else begin
						cur_d = rd_next;
					end
				end
				lldq_pkg::OP_GET: begin
					if (!cv_q) begin
						st_d = lldq_pkg::ST_NO_CURSOR;
					end else begin
						pay_d = rd_pay;
					end
				end
				lldq_pkg::OP_REMOVE: begin
					n_end = cur_q;
					if (!cv_q) begin
						st_d = lldq_pkg::ST_NO_CURSOR;
					end else begin
						if (cnt_q == CW'(1)) begin
							cv_d = 1'b0;
							st_d = lldq_pkg::ST_ENDED;
						end else if (cur_q == head_q) begin
							head_d = rd_next;
							cur_d  = rd_next;
						end else if (cur_q == tail_q) begin
							tail_d = rd_prev;
							cur_d  = rd_prev;
						end else begin
							// splice the neighbours together
							nxt_we = 1'b1;
							nxt_wa = rd_prev;
							nxt_wd = rd_next;
							prv_we = 1'b1;
							prv_wa = rd_next;
							prv_wd = rd_prev;
							cur_d  = rd_next;
						end
						fs_we = 1'b1;
						sc_d  = sc_q + CW'(1);
						cnt_d = cnt_q - CW'(1);
					end
				end
				lldq_pkg::OP_CLEAR: begin
					cnt_d   = '0;
					sc_d    = '0;
					fresh_d = '0;
					cv_d    = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lldq_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Command capture
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			op_s1   <= cmd.opcode;
			word_s1 <= cmd.payload_in;
		end
	end

	// List registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			cur_q   <= '0;
			cv_q    <= 1'b0;
			cnt_q   <= '0;
			sc_q    <= '0;
			fresh_q <= '0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			cur_q   <= cur_d;
			cv_q    <= cv_d;
			cnt_q   <= cnt_d;
			sc_q    <= sc_d;
			fresh_q <= fresh_d;
		end
	end

	// Response register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (exec_go) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Response register payload
	always_ff @(posedge clk) begin
		if (exec_go) begin
			out_st_q  <= st_d;
			out_pay_q <= pay_d;
			out_cnt_q <= cnt_d;
			out_cv_q  <= cv_d;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.status        = out_st_q;
	assign rsp.payload_out   = out_pay_q;
	assign rsp.element_count = out_cnt_q;
	assign rsp.cursor_valid  = out_cv_q;

	// Every node is either live, on the returned stack or not yet handed out
	a_pool_balance: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, sc_q} + {1'b0, cnt_q}) == {1'b0, fresh_q})
		else $error("free pool accounting broken");

	// List never holds more than its node count
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("element count beyond node count");

	// A valid cursor needs a non-empty list
	a_cursor_live: assert property (@(posedge clk) disable iff (!arst_n)
		cv_q |-> (cnt_q != '0))
		else $error("cursor valid on empty list");

	// A command transfer is always followed by the execute step
	a_exec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer |=> (state_q == lldq_pkg::SEQ_EXEC) && !cmd.ready)
		else $error("command not executed after transfer");

endmodule
